>>> src/rounded_rect_aa_fill_core_macros.svh
// Assertion macros for the checker file of the rounded rectangle fill core.
// No dependencies; include with the bare file name.
`ifndef ROUNDED_RECT_AA_FILL_CORE_MACROS_SVH
`define ROUNDED_RECT_AA_FILL_CORE_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define RRECT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rounded rect fill check failed");

// Concurrent check that also runs through reset.
`define RRECT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rounded rect fill reset check failed");

`endif

>>> src/rrect_pkg.sv
// Shared types and constants of the rounded rectangle fill core.
// Used by every RTL module of the block; no dependencies.
package rrect_pkg;

  localparam int LEFT_W     = 13;
  localparam int SIDE_W     = 12;
  localparam int RAD_W      = 8;
  localparam int CH_W       = 8;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Shift of the fixed-point reciprocal used to divide by the subsample count.
  localparam int RECIP_SHIFT = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT      = 3'd0,
    REG_RECT_TOP       = 3'd1,
    REG_RECT_WIDTH     = 3'd2,
    REG_RECT_HEIGHT    = 3'd3,
    REG_CORNER_RADIUS  = 3'd4,
    REG_FILL_COLOR     = 3'd5,
    REG_SURFACE_WIDTH  = 3'd6,
    REG_SURFACE_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic signed [LEFT_W-1:0] rect_left;
    logic signed [LEFT_W-1:0] rect_top;
    logic [SIDE_W-1:0]        rect_width;
    logic [SIDE_W-1:0]        rect_height;
    logic [RAD_W-1:0]         corner_radius;
    color_t                   fill_color;
    logic [SIDE_W-1:0]        surface_width;
    logic [SIDE_W-1:0]        surface_height;
  } cfg_t;

  typedef struct packed {
    logic in_rect;
    logic strip;
  } pix_ctl_t;

endpackage

>>> src/rrect_cfg.sv
// Configuration register file of the rounded rectangle fill core.
// Depends on rrect_pkg for the register map and cfg_t.
module rrect_cfg
  import rrect_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RECT_LEFT:      regs.rect_left      <= cfg_data[LEFT_W-1:0];
        REG_RECT_TOP:       regs.rect_top       <= cfg_data[LEFT_W-1:0];
        REG_RECT_WIDTH:     regs.rect_width     <= cfg_data[SIDE_W-1:0];
        REG_RECT_HEIGHT:    regs.rect_height    <= cfg_data[SIDE_W-1:0];
        REG_CORNER_RADIUS:  regs.corner_radius  <= cfg_data[RAD_W-1:0];
        REG_FILL_COLOR:     regs.fill_color     <= color_t'(cfg_data[3*CH_W-1:0]);
        REG_SURFACE_WIDTH:  regs.surface_width  <= cfg_data[SIDE_W-1:0];
        REG_SURFACE_HEIGHT: regs.surface_height <= cfg_data[SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> src/rrect_geom.sv
// Geometry stages: clip test, local offsets, radius limit, strip test and
// per-subsample distances to the clamped corner centre. Depends on rrect_pkg.
module rrect_geom
  import rrect_pkg::*;
#(
  parameter int COORD_BITS          = 12,
  parameter int SUBSAMPLES_PER_AXIS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_vld,
  output logic                  in_rdy,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  color_t                dst,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output pix_ctl_t              out_ctl,
  output color_t                out_dst,
  output logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] out_dxm [SUBSAMPLES_PER_AXIS],
  output logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] out_dym [SUBSAMPLES_PER_AXIS],
  output logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] out_rs
);

  localparam int S    = SUBSAMPLES_PER_AXIS;
  localparam int SC   = 2 * S;
  localparam int DM_W = $clog2(255 * SC + 1);
  localparam int XW   = ((COORD_BITS > LEFT_W) ? COORD_BITS : LEFT_W) + 2;
  localparam int FX_W = SIDE_W + $clog2(SC) + 1;

  // stage 1
  logic                    g1_v;
  logic                    g1_in;
  logic [SIDE_W-1:0]       g1_lx;
  logic [SIDE_W-1:0]       g1_ly;
  logic [RAD_W-1:0]        g1_r;
  color_t                  g1_dst;
  // stage 2
  logic                    g2_v;
  pix_ctl_t                g2_ctl;
  color_t                  g2_dst;
  logic [DM_W-1:0]         g2_dxm [S];
  logic [DM_W-1:0]         g2_dym [S];
  logic [DM_W-1:0]         g2_rs;

  logic g1_rdy, g2_rdy;

  logic signed [XW-1:0] px_s, py_s, left_s, top_s, lx_s, ly_s;
  logic signed [XW-1:0] w_s, h_s, sw_s, sh_s;
  logic                 in_rect;
  logic [SIDE_W-1:0]    min_side, half;
  logic [RAD_W-1:0]     r;

  logic [SIDE_W-1:0]    w_minus_r, h_minus_r;
  logic                 strip;
  logic [FX_W-1:0]      lo, xhi, yhi;
  logic [FX_W-1:0]      fx [S];
  logic [FX_W-1:0]      fy [S];
  logic [FX_W-1:0]      ddx [S];
  logic [FX_W-1:0]      ddy [S];

  assign g2_rdy = !g2_v || out_rdy;
  assign g1_rdy = !g1_v || g2_rdy;
  assign in_rdy = g1_rdy;

  // Clip and offsets
  always_comb begin
    px_s   = signed'(XW'(pixel_x));
    py_s   = signed'(XW'(pixel_y));
    left_s = XW'(cfg.rect_left);
    top_s  = XW'(cfg.rect_top);
    w_s    = signed'(XW'(cfg.rect_width));
    h_s    = signed'(XW'(cfg.rect_height));
    sw_s   = signed'(XW'(cfg.surface_width));
    sh_s   = signed'(XW'(cfg.surface_height));
    lx_s   = px_s - left_s;
    ly_s   = py_s - top_s;
    in_rect = !lx_s[XW-1] && (lx_s < w_s) && (px_s < sw_s) &&
              !ly_s[XW-1] && (ly_s < h_s) && (py_s < sh_s);
    min_side = (cfg.rect_width < cfg.rect_height) ? cfg.rect_width : cfg.rect_height;
    half     = min_side >> 1;
    r        = (SIDE_W'(cfg.corner_radius) < half) ? cfg.corner_radius : half[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_v <= 1'b0;
    end else if (g1_rdy) begin
      g1_v <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (g1_rdy) begin
      g1_in  <= in_rect;
      g1_lx  <= lx_s[SIDE_W-1:0];
      g1_ly  <= ly_s[SIDE_W-1:0];
      g1_r   <= r;
      g1_dst <= dst;
    end
  end

  // Strip test and distances from each subsample to the clamped centre
  always_comb begin
    w_minus_r = cfg.rect_width - SIDE_W'(g1_r);
    h_minus_r = cfg.rect_height - SIDE_W'(g1_r);
    strip = ((g1_ly >= SIDE_W'(g1_r)) && (g1_ly < h_minus_r)) ||
            ((g1_lx >= SIDE_W'(g1_r)) && (g1_lx < w_minus_r));
    lo  = FX_W'(g1_r) * FX_W'(SC);
    xhi = FX_W'(w_minus_r) * FX_W'(SC);
    yhi = FX_W'(h_minus_r) * FX_W'(SC);
    for (int s = 0; s < S; s++) begin
      fx[s] = FX_W'(g1_lx) * FX_W'(SC) + FX_W'(2 * s + 1);
      fy[s] = FX_W'(g1_ly) * FX_W'(SC) + FX_W'(2 * s + 1);
      ddx[s] = (fx[s] < lo) ? (lo - fx[s]) : ((fx[s] > xhi) ? (fx[s] - xhi) : '0);
      ddy[s] = (fy[s] < lo) ? (lo - fy[s]) : ((fy[s] > yhi) ? (fy[s] - yhi) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_v <= 1'b0;
    end else if (g2_rdy) begin
      g2_v <= g1_v;
    end
  end

  // Distances exceed DM_W bits only for clipped pixels, where coverage is not used.
  always_ff @(posedge clk) begin
    if (g2_rdy) begin
      g2_ctl.in_rect <= g1_in;
      g2_ctl.strip   <= strip;
      g2_dst         <= g1_dst;
      g2_rs          <= lo[DM_W-1:0];
      for (int s = 0; s < S; s++) begin
        g2_dxm[s] <= ddx[s][DM_W-1:0];
        g2_dym[s] <= ddy[s][DM_W-1:0];
      end
    end
  end

  assign out_vld = g2_v;
  assign out_ctl = g2_ctl;
  assign out_dst = g2_dst;
  assign out_dxm = g2_dxm;
  assign out_dym = g2_dym;
  assign out_rs  = g2_rs;

endmodule

>>> src/rrect_cover.sv
// Coverage stages: squared distances, per-subsample hit test, hit count.
// Depends on rrect_pkg; fed by rrect_geom.
module rrect_cover
  import rrect_pkg::*;
#(
  parameter int SUBSAMPLES_PER_AXIS = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_vld,
  output logic     in_rdy,
  input  pix_ctl_t in_ctl,
  input  color_t   in_dst,
  input  logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] in_dxm [SUBSAMPLES_PER_AXIS],
  input  logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] in_dym [SUBSAMPLES_PER_AXIS],
  input  logic [$clog2(255*2*SUBSAMPLES_PER_AXIS+1)-1:0] in_rs,
  output logic     out_vld,
  input  logic     out_rdy,
  output logic     out_write,
  output color_t   out_dst,
  output logic [$clog2(SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS+1)-1:0] out_hits
);

  localparam int S    = SUBSAMPLES_PER_AXIS;
  localparam int T    = S * S;
  localparam int DM_W = $clog2(255 * 2 * S + 1);
  localparam int SQ_W = 2 * DM_W;
  localparam int RC_W = $clog2(S + 1);
  localparam int HW   = $clog2(T + 1);

  // stage 1: squares
  logic              c1_v;
  pix_ctl_t          c1_ctl;
  color_t            c1_dst;
  logic [SQ_W-1:0]   c1_sqx [S];
  logic [SQ_W-1:0]   c1_sqy [S];
  logic [SQ_W-1:0]   c1_r2;
  // stage 2: hit count per subsample row
  logic              c2_v;
  pix_ctl_t          c2_ctl;
  color_t            c2_dst;
  logic [RC_W-1:0]   c2_row [S];
  // stage 3: total, forced for strip and clipped pixels
  logic              c3_v;
  logic              c3_write;
  color_t            c3_dst;
  logic [HW-1:0]     c3_hits;

  logic c1_rdy, c2_rdy, c3_rdy;
  logic [RC_W-1:0] row_sum [S];
  logic [HW-1:0]   tot, hits_next;

  assign c3_rdy = !c3_v || out_rdy;
  assign c2_rdy = !c2_v || c3_rdy;
  assign c1_rdy = !c1_v || c2_rdy;
  assign in_rdy = c1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
    end else begin
      if (c1_rdy) c1_v <= in_vld;
      if (c2_rdy) c2_v <= c1_v;
      if (c3_rdy) c3_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c1_rdy) begin
      c1_ctl <= in_ctl;
      c1_dst <= in_dst;
      c1_r2  <= SQ_W'(in_rs) * SQ_W'(in_rs);
      for (int s = 0; s < S; s++) begin
        c1_sqx[s] <= SQ_W'(in_dxm[s]) * SQ_W'(in_dxm[s]);
        c1_sqy[s] <= SQ_W'(in_dym[s]) * SQ_W'(in_dym[s]);
      end
    end
  end

  always_comb begin
    for (int sy = 0; sy < S; sy++) begin
      row_sum[sy] = '0;
      for (int sx = 0; sx < S; sx++) begin
        if (({1'b0, c1_sqx[sx]} + {1'b0, c1_sqy[sy]}) <= {1'b0, c1_r2}) begin
          row_sum[sy] = row_sum[sy] + RC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c2_rdy) begin
      c2_ctl <= c1_ctl;
      c2_dst <= c1_dst;
      c2_row <= row_sum;
    end
  end

  // Clipped pixels blend with no hits, strip pixels with full coverage.
  always_comb begin
    tot = '0;
    for (int sy = 0; sy < S; sy++) begin
      tot = tot + HW'(c2_row[sy]);
    end
    if (!c2_ctl.in_rect) begin
      hits_next = '0;
    end else if (c2_ctl.strip) begin
      hits_next = HW'(T);
    end else begin
      hits_next = tot;
    end
  end

  always_ff @(posedge clk) begin
    if (c3_rdy) begin
      c3_write <= c2_ctl.in_rect;
      c3_dst   <= c2_dst;
      c3_hits  <= hits_next;
    end
  end

  assign out_vld   = c3_v;
  assign out_write = c3_write;
  assign out_dst   = c3_dst;
  assign out_hits  = c3_hits;

endmodule

>>> src/rrect_blend.sv
// Blend stages: weighted sum of destination and fill colour, then rounding
// division by the subsample count through a reciprocal. Depends on rrect_pkg.
module rrect_blend
  import rrect_pkg::*;
#(
  parameter int SUBSAMPLES_PER_AXIS = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  color_t fill,
  input  logic   in_vld,
  output logic   in_rdy,
  input  logic   in_write,
  input  color_t in_dst,
  input  logic [$clog2(SUBSAMPLES_PER_AXIS*SUBSAMPLES_PER_AXIS+1)-1:0] in_hits,
  output logic   out_vld,
  input  logic   out_rdy,
  output logic   out_write,
  output color_t out_color
);

  localparam int T     = SUBSAMPLES_PER_AXIS * SUBSAMPLES_PER_AXIS;
  localparam int HW    = $clog2(T + 1);
  localparam int NW    = $clog2(255 * T + T / 2 + 1);
  localparam int RECIP = (2 ** RECIP_SHIFT + T - 1) / T;
  localparam int PW    = NW + RECIP_SHIFT + 1;

  localparam logic [HW-1:0] T_HW = HW'(T);

  logic          b1_v;
  logic          b1_write;
  logic [NW-1:0] b1_nb, b1_ng, b1_nr;
  logic          b2_v;
  logic          b2_write;
  color_t        b2_color;

  logic b1_rdy, b2_rdy;
  logic [HW-1:0] inv_hits;
  logic [PW-1:0] pb, pg, pr;

  assign b2_rdy = !b2_v || out_rdy;
  assign b1_rdy = !b1_v || b2_rdy;
  assign in_rdy = b1_rdy;

  assign inv_hits = T_HW - in_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
    end else begin
      if (b1_rdy) b1_v <= in_vld;
      if (b2_rdy) b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_rdy) begin
      b1_write <= in_write;
      b1_nb <= NW'(in_dst.blue) * NW'(inv_hits) + NW'(fill.blue) * NW'(in_hits) + NW'(T / 2);
      b1_ng <= NW'(in_dst.green) * NW'(inv_hits) + NW'(fill.green) * NW'(in_hits)
               + NW'(T / 2);
      b1_nr <= NW'(in_dst.red) * NW'(inv_hits) + NW'(fill.red) * NW'(in_hits) + NW'(T / 2);
    end
  end

  // Reciprocal error stays below one part in T for sums under 256*T.
  assign pb = PW'(b1_nb) * PW'(RECIP);
  assign pg = PW'(b1_ng) * PW'(RECIP);
  assign pr = PW'(b1_nr) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (b2_rdy) begin
      b2_write       <= b1_write;
      b2_color.blue  <= pb[RECIP_SHIFT +: CH_W];
      b2_color.green <= pg[RECIP_SHIFT +: CH_W];
      b2_color.red   <= pr[RECIP_SHIFT +: CH_W];
    end
  end

  assign out_vld   = b2_v;
  assign out_write = b2_write;
  assign out_color = b2_color;

endmodule

>>> src/rounded_rect_aa_fill_core.sv
// Anti-aliased rounded rectangle fill, one destination pixel per item.
// Pixel channel: pix_valid/pix_stall with pixel_x, pixel_y and the current
// blue, green and red bytes. Result channel: res_valid/res_stall with
// write_enable and the new bytes. An item moves when valid is high and
// stall is low.
// Between pixel and result the pipeline has two geometry stages, three
// coverage stages (squares, hit test, count) and two blend stages (weighted
// sum, reciprocal multiply, which is the output register).
// Throughput is one pixel per cycle while res_stall is low; each stage holds
// one item and moves on when the stage after it is empty or moving.
// When the receiver stalls, full stages hold their items and pix_stall rises
// only once every stage is occupied; nothing is dropped or repeated.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once; the
// user must make them only while no pixel is in flight, which the block does
// not enforce. Reset clears the configuration registers to zero and empties
// the pipeline; no clearing pass is needed. Depends on rrect_pkg and the rrect_* submodules.
module rounded_rect_aa_fill_core
  import rrect_pkg::*;
#(
  parameter int COORD_BITS          = 12,
  parameter int SUBSAMPLES_PER_AXIS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [CH_W-1:0]       dst_blue,
  input  logic [CH_W-1:0]       dst_green,
  input  logic [CH_W-1:0]       dst_red,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  write_enable,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_red
);

  localparam int S    = SUBSAMPLES_PER_AXIS;
  localparam int DM_W = $clog2(255 * 2 * S + 1);
  localparam int HW   = $clog2(S * S + 1);

  cfg_t cfg;

  logic            geom_rdy;
  color_t          dst;
  logic            g_vld, g_rdy;
  pix_ctl_t        g_ctl;
  color_t          g_dst;
  logic [DM_W-1:0] g_dxm [S];
  logic [DM_W-1:0] g_dym [S];
  logic [DM_W-1:0] g_rs;

  logic            c_vld, c_rdy, c_write;
  color_t          c_dst;
  logic [HW-1:0]   c_hits;

  color_t          res_color;

  assign dst.blue  = dst_blue;
  assign dst.green = dst_green;
  assign dst.red   = dst_red;

  rrect_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rrect_geom #(
    .COORD_BITS          (COORD_BITS),
    .SUBSAMPLES_PER_AXIS (SUBSAMPLES_PER_AXIS)
  ) u_geom (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_vld  (pix_valid),
    .in_rdy  (geom_rdy),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .dst     (dst),
    .out_vld (g_vld),
    .out_rdy (g_rdy),
    .out_ctl (g_ctl),
    .out_dst (g_dst),
    .out_dxm (g_dxm),
    .out_dym (g_dym),
    .out_rs  (g_rs)
  );

  rrect_cover #(
    .SUBSAMPLES_PER_AXIS (SUBSAMPLES_PER_AXIS)
  ) u_cover (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (g_vld),
    .in_rdy    (g_rdy),
    .in_ctl    (g_ctl),
    .in_dst    (g_dst),
    .in_dxm    (g_dxm),
    .in_dym    (g_dym),
    .in_rs     (g_rs),
    .out_vld   (c_vld),
    .out_rdy   (c_rdy),
    .out_write (c_write),
    .out_dst   (c_dst),
    .out_hits  (c_hits)
  );

  rrect_blend #(
    .SUBSAMPLES_PER_AXIS (SUBSAMPLES_PER_AXIS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .fill      (cfg.fill_color),
    .in_vld    (c_vld),
    .in_rdy    (c_rdy),
    .in_write  (c_write),
    .in_dst    (c_dst),
    .in_hits   (c_hits),
    .out_vld   (res_valid),
    .out_rdy   (!res_stall),
    .out_write (write_enable),
    .out_color (res_color)
  );

  assign pix_stall = !geom_rdy;
  assign out_blue  = res_color.blue;
  assign out_green = res_color.green;
  assign out_red   = res_color.red;

endmodule

>>> src/rrect_checker.sv
// Port-level checks of the rounded rectangle fill core, bound to the top level.
// Depends on rounded_rect_aa_fill_core_macros.svh.
`include "rounded_rect_aa_fill_core_macros.svh"

module rrect_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_valid,
  input logic       pix_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic       write_enable,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red
);

  // Reset empties the pipeline and opens the input.
  `RRECT_ASSERT_NR(a_reset_empty, clk, rst |=> (!res_valid && !pix_stall))

  // The input backs up only behind a full, stalled output.
  `RRECT_ASSERT(a_stall_source, clk, rst, (pix_valid && pix_stall) |-> (res_valid && res_stall))

  `RRECT_ASSERT(a_res_hold, clk, rst, (res_valid && res_stall) |=> res_valid)

  `RRECT_ASSERT(a_res_stable, clk, rst, (res_valid && res_stall) |=> ($stable(write_enable) && $stable(out_blue) && $stable(out_green) && $stable(out_red)))

endmodule

bind rounded_rect_aa_fill_core rrect_checker u_rrect_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pix_valid),
  .pix_stall    (pix_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .write_enable (write_enable),
  .out_blue     (out_blue),
  .out_green    (out_green),
  .out_red      (out_red)
);
